// ----- design/pfa_pkg.sv -----
// Shared constants, codes and types for the paged frame allocator.
// Depends on nothing; imported by every module of the block.
package pfa_pkg;

    localparam int PAGE_OFFSET_BITS = 8;
    localparam int VIRT_PAGE_BITS   = 6;
    localparam int NUM_FRAMES       = 64;
    localparam int NUM_PROCS        = 8;

    localparam int OP_W   = 2;
    localparam int PID_W  = 4;
    localparam int SIZE_W = 15;
    localparam int ADDR_W = 14;
    localparam int DATA_W = 8;

    localparam int FRAME_BITS      = $clog2(NUM_FRAMES);
    localparam int CNT_BITS        = FRAME_BITS + 1;
    localparam int PROC_BITS       = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int BRK_BITS        = VIRT_PAGE_BITS + 1;
    localparam int N_BITS          = SIZE_W + 1 - PAGE_OFFSET_BITS;
    localparam int PM_ADDR_BITS    = PROC_BITS + VIRT_PAGE_BITS;
    localparam int PM_DEPTH        = NUM_PROCS << VIRT_PAGE_BITS;
    localparam int STORE_ADDR_BITS = FRAME_BITS + PAGE_OFFSET_BITS;
    localparam int STORE_DEPTH     = NUM_FRAMES << PAGE_OFFSET_BITS;
    localparam int VIRT_PAGES      = 1 << VIRT_PAGE_BITS;
    localparam int CLR_DEPTH       = (STORE_DEPTH > PM_DEPTH) ? STORE_DEPTH : PM_DEPTH;
    localparam int CLR_BITS        = $clog2(CLR_DEPTH);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd3;

    typedef struct packed {
        logic [PID_W-1:0]      owner;
        logic [FRAME_BITS-1:0] seq;
        logic                  last;
    } frame_info_t;

    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] frame;
    } pm_entry_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan;
        logic idx_clr;
        logic idx_inc;
        logic cnt_inc;
        logic pick;
        logic alloc_fin;
        logic fr_from_map;
        logic fr_from_next;
        logic walk_clr;
        logic byte_wr;
        logic finish;
        logic fail;
        logic fin_region;
        logic fin_rdata;
    } pfa_cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic            pid_ok;
        logic [OP_W-1:0] op;
        logic            alloc_bad;
        logic            n_zero;
        logic            frame_free;
        logic            cnt_hit;
        logic            idx_last;
        logic            map_valid;
        logic            owner_ok;
        logic            head_ok;
        logic            frame_last;
    } pfa_stat_t;

endpackage

// ----- design/pfa_dp.sv -----
// Datapath of the paged frame allocator: request registers, frame tables,
// page map, break registers, byte store and result registers. Uses pfa_pkg.
module pfa_dp
    import pfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfa_cmd_t            cmd,
    output pfa_stat_t           stat,
    input  logic [OP_W-1:0]     opcode,
    input  logic [PID_W-1:0]    process_id,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    output logic                done,
    output logic                status,
    output logic [ADDR_W-1:0]   region_address,
    output logic [DATA_W-1:0]   read_data
);

    logic [OP_W-1:0]       op_reg;
    logic [PID_W-1:0]      pid_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [FRAME_BITS-1:0] idx_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [FRAME_BITS-1:0] fr_reg;
    logic [FRAME_BITS-1:0] prev_reg;
    logic [CLR_BITS-1:0]   clr_reg;
    logic [BRK_BITS-1:0]   brk_reg [NUM_PROCS];
    logic                  done_reg;
    logic                  status_reg;
    logic [ADDR_W-1:0]     region_reg;
    logic [DATA_W-1:0]     rdata_reg;

    frame_info_t           info_mem [NUM_FRAMES];
    logic [FRAME_BITS-1:0] next_mem [NUM_FRAMES];
    pm_entry_t             pm_mem [PM_DEPTH];
    logic [DATA_W-1:0]     byte_mem [STORE_DEPTH];

    frame_info_t           info_q;
    logic [FRAME_BITS-1:0] next_q;
    pm_entry_t             pm_q;
    logic [DATA_W-1:0]     byte_q;

    logic [PID_W-1:0]           pid_m1;
    logic [PROC_BITS-1:0]       pidx;
    logic [VIRT_PAGE_BITS-1:0]  vpn;
    logic [PAGE_OFFSET_BITS-1:0] off;
    logic [BRK_BITS-1:0]        bp;
    logic [SIZE_W:0]            size_up;
    logic [N_BITS-1:0]          n_pages;
    logic [N_BITS+1:0]          bp_sum;
    logic [BRK_BITS+PAGE_OFFSET_BITS-1:0] region_wide;
    logic [BRK_BITS-1:0]        map_page;
    logic [FRAME_BITS-1:0]      info_raddr;

    logic                  info_we;
    logic [FRAME_BITS-1:0] info_waddr;
    frame_info_t           info_wdata;
    logic                  next_we;
    logic [FRAME_BITS-1:0] next_waddr;
    logic [FRAME_BITS-1:0] next_wdata;
    logic                  pm_we;
    logic [PM_ADDR_BITS-1:0] pm_waddr;
    pm_entry_t             pm_wdata;
    logic                  byte_we;
    logic [STORE_ADDR_BITS-1:0] byte_waddr;
    logic [DATA_W-1:0]     byte_wdata;
    logic                  clr_in_pm;
    logic                  clr_in_frames;

    assign pid_m1      = pid_reg - PID_W'(1);
    assign pidx        = pid_m1[PROC_BITS-1:0];
    assign vpn         = addr_reg[PAGE_OFFSET_BITS +: VIRT_PAGE_BITS];
    assign off         = addr_reg[PAGE_OFFSET_BITS-1:0];
    assign bp          = brk_reg[pidx];
    assign size_up     = {1'b0, size_reg} + (SIZE_W+1)'((1 << PAGE_OFFSET_BITS) - 1);
    assign n_pages     = size_up[SIZE_W:PAGE_OFFSET_BITS];
    assign bp_sum      = (N_BITS+2)'(bp) + (N_BITS+2)'(n_pages);
    assign region_wide = {bp, {PAGE_OFFSET_BITS{1'b0}}};
    assign map_page    = bp + BRK_BITS'(cnt_reg);
    assign info_raddr  = cmd.scan ? idx_reg : fr_reg;

    assign clr_in_pm     = {1'b0, clr_reg} < (CLR_BITS+1)'(PM_DEPTH);
    assign clr_in_frames = {1'b0, clr_reg} < (CLR_BITS+1)'(NUM_FRAMES);

    always_comb
    begin
        stat.clr_last   = clr_reg == CLR_BITS'(CLR_DEPTH - 1);
        stat.pid_ok     = (pid_reg != '0) && (pid_reg <= PID_W'(NUM_PROCS));
        stat.op         = op_reg;
        stat.alloc_bad  = (n_pages > N_BITS'(NUM_FRAMES)) || (bp_sum > (N_BITS+2)'(VIRT_PAGES));
        stat.n_zero     = n_pages == '0;
        stat.frame_free = info_q.owner == '0;
        stat.cnt_hit    = (N_BITS+1)'(cnt_reg) + (N_BITS+1)'(1) == (N_BITS+1)'(n_pages);
        stat.idx_last   = idx_reg == FRAME_BITS'(NUM_FRAMES - 1);
        stat.map_valid  = pm_q.valid;
        stat.owner_ok   = info_q.owner == pid_reg;
        stat.head_ok    = (info_q.owner == pid_reg) && (info_q.seq == '0);
        stat.frame_last = info_q.last;
    end

    always_comb
    begin
        info_we    = 1'b0;
        info_waddr = idx_reg;
        info_wdata = '0;
        next_we    = 1'b0;
        next_waddr = prev_reg;
        next_wdata = '0;
        pm_we      = 1'b0;
        pm_waddr   = {pidx, map_page[VIRT_PAGE_BITS-1:0]};
        pm_wdata   = '0;
        byte_we    = 1'b0;
        byte_waddr = {fr_reg, off};
        byte_wdata = wdata_reg;
        if (cmd.clr_step)
        begin
            byte_we    = 1'b1;
            byte_waddr = clr_reg[STORE_ADDR_BITS-1:0];
            byte_wdata = '0;
            pm_we      = clr_in_pm;
            pm_waddr   = clr_reg[PM_ADDR_BITS-1:0];
            info_we    = clr_in_frames;
            info_waddr = clr_reg[FRAME_BITS-1:0];
            next_we    = clr_in_frames;
            next_waddr = clr_reg[FRAME_BITS-1:0];
        end
        else
        begin
            if (cmd.pick)
            begin
                info_we          = 1'b1;
                info_wdata.owner = pid_reg;
                info_wdata.seq   = cnt_reg[FRAME_BITS-1:0];
                info_wdata.last  = stat.cnt_hit;
                next_we          = cnt_reg != '0;
                next_wdata       = idx_reg;
                pm_we            = 1'b1;
                pm_wdata.valid   = 1'b1;
                pm_wdata.frame   = idx_reg;
            end
            if (cmd.alloc_fin)
            begin
                next_we = 1'b1;
            end
            if (cmd.walk_clr)
            begin
                info_we          = 1'b1;
                info_waddr       = fr_reg;
                info_wdata       = info_q;
                info_wdata.owner = '0;
            end
            byte_we = cmd.byte_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[info_waddr] <= info_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (pm_we)
        begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        info_q <= info_mem[info_raddr];
        next_q <= next_mem[fr_reg];
        pm_q   <= pm_mem[{pidx, vpn}];
        byte_q <= byte_mem[{fr_reg, off}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            pid_reg   <= process_id;
            size_reg  <= request_size;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + FRAME_BITS'(1);
            end
            if (cmd.cnt_inc || cmd.pick)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
        end
        if (cmd.pick)
        begin
            prev_reg <= idx_reg;
        end
        if (cmd.fr_from_map)
        begin
            fr_reg <= pm_q.frame;
        end
        else if (cmd.fr_from_next)
        begin
            fr_reg <= next_q;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fail;
            region_reg <= (cmd.fin_region && !cmd.fail) ? ADDR_W'(region_wide) : '0;
            rdata_reg  <= (cmd.fin_rdata && !cmd.fail) ? byte_q : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                brk_reg[p] <= BRK_BITS'(1);
            end
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CLR_BITS'(1);
            end
            if (cmd.alloc_fin)
            begin
                brk_reg[pidx] <= BRK_BITS'(bp_sum);
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign region_address = region_reg;
    assign read_data      = rdata_reg;

endmodule

// ----- design/pfa_ctrl.sv -----
// Controller of the paged frame allocator: sequences clearing, frame scans,
// chain walks and translations. Uses pfa_pkg; drives pfa_dp through pfa_cmd_t.
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pfa_stat_t stat,
    output pfa_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_DISP   = 15'b000000000000100,
        S_A_RD   = 15'b000000000001000,
        S_A_EV   = 15'b000000000010000,
        S_B_RD   = 15'b000000000100000,
        S_B_EV   = 15'b000000001000000,
        S_A_FIN  = 15'b000000010000000,
        S_M_CHK  = 15'b000000100000000,
        S_F_RD0  = 15'b000001000000000,
        S_F_EV0  = 15'b000010000000000,
        S_F_RD   = 15'b000100000000000,
        S_F_EV   = 15'b001000000000000,
        S_L_RD   = 15'b010000000000000,
        S_L_OWN  = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   data_reg;
    logic   data_next;

    always_comb
    begin
        state_next = state_reg;
        data_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (data_reg)
                begin
                    cmd.finish    = 1'b1;
                    cmd.fin_rdata = 1'b1;
                end
                else if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!stat.pid_ok)
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.op == OP_ALLOC)
                begin
                    if (stat.alloc_bad)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fail   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.n_zero)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_region = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_A_RD;
                    end
                end
                else
                begin
                    state_next = S_M_CHK;
                end
            end
            S_A_RD:
            begin
                cmd.scan   = 1'b1;
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                if (stat.frame_free && stat.cnt_hit)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_B_RD;
                end
                else if (stat.idx_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.cnt_inc = stat.frame_free;
                    state_next  = S_A_RD;
                end
            end
            S_B_RD:
            begin
                cmd.scan   = 1'b1;
                state_next = S_B_EV;
            end
            S_B_EV:
            begin
                cmd.pick = stat.frame_free;
                if (stat.frame_free && stat.cnt_hit)
                begin
                    state_next = S_A_FIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_B_RD;
                end
            end
            S_A_FIN:
            begin
                cmd.alloc_fin  = 1'b1;
                cmd.finish     = 1'b1;
                cmd.fin_region = 1'b1;
                state_next     = S_IDLE;
            end
            S_M_CHK:
            begin
                if (!stat.map_valid)
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.fr_from_map = 1'b1;
                    cmd.idx_clr     = 1'b1;
                    state_next      = (stat.op == OP_FREE) ? S_F_RD0 : S_L_RD;
                end
            end
            S_F_RD0:
            begin
                state_next = S_F_EV0;
            end
            S_F_RD:
            begin
                state_next = S_F_EV;
            end
            S_F_EV0, S_F_EV:
            begin
                if ((state_reg == S_F_EV0) && !stat.head_ok)
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_clr = 1'b1;
                    if (stat.frame_last || stat.idx_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc      = 1'b1;
                        cmd.fr_from_next = 1'b1;
                        state_next       = S_F_RD;
                    end
                end
            end
            S_L_RD:
            begin
                state_next = S_L_OWN;
            end
            S_L_OWN:
            begin
                if (!stat.owner_ok)
                begin
                    cmd.finish = 1'b1;
                    cmd.fail   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.op == OP_WRITE)
                begin
                    cmd.byte_wr = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    data_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            data_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            data_reg  <= data_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || data_reg;

endmodule

// ----- design/paged_frame_allocator_mmu.sv -----
// Top level of the paged frame allocator with single-level page translation.
// Joins pfa_ctrl and pfa_dp; uses pfa_pkg.
//
// Usage:
//   Drive opcode, process_id, request_size, address and write_data and raise
//   start; the request is taken at a rising edge with start high, busy low.
//   Exactly one result follows: done is high for one cycle with status,
//   region_address and read_data valid. The receiver cannot stall; take the
//   result in that cycle.
// Request paths, from the accepted request to done, by the states they end in:
//   bad process id, failed allocate check, zero-size allocate: S_DISP
//   unmapped page: S_M_CHK; refused free or frame not owned: S_F_EV0, S_L_OWN
//   write: S_L_OWN; read: S_L_OWN, then the byte is read out in S_IDLE
//   allocate: a scan for enough free frames (S_A_RD, S_A_EV), a scan that
//             assigns them (S_B_RD, S_B_EV), then S_A_FIN
//   free: a chain walk over the frames in the region (S_F_RD, S_F_EV)
//   The scans and the chain walk read one frame table entry per state pair.
// A new request is accepted in the cycle done is shown.
// Reset: busy stays high for 16384 cycles while the byte store, page map
//   and frame tables are swept to zero, one entry per cycle.
module paged_frame_allocator_mmu
    import pfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     opcode,
    input  logic [PID_W-1:0]    process_id,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    output logic                done,
    output logic                status,
    output logic [ADDR_W-1:0]   region_address,
    output logic [DATA_W-1:0]   read_data
);

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    pfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pfa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .process_id     (process_id),
        .request_size   (request_size),
        .address        (address),
        .write_data     (write_data),
        .done           (done),
        .status         (status),
        .region_address (region_address),
        .read_data      (read_data)
    );

endmodule

// ----- design/pfa_checker.sv -----
// Port-level checker for the paged frame allocator, bound to the top level.
// Depends on pfa_pkg and paged_frame_allocator_mmu.
module pfa_checker
    import pfa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              status,
    input logic [ADDR_W-1:0] region_address,
    input logic [DATA_W-1:0] read_data
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (region_address == '0) && (read_data == '0))
        else $error("failed request returned nonzero data");

endmodule

bind paged_frame_allocator_mmu pfa_checker u_pfa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .region_address (region_address),
    .read_data      (read_data)
);

// ----- tb/tb_paged_frame_allocator_mmu.sv -----
// Self-checking bench for paged_frame_allocator_mmu: allocate, free, read, write requests.
// Behavioral predictor of frame tables, page maps and byte store; depends on pfa_pkg.
`timescale 1ns / 1ps
module tb_paged_frame_allocator_mmu;
    import pfa_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PID_W-1:0]  pid;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic              hold;
    } mem_req_t;

    typedef struct packed {
        logic              st;
        logic [ADDR_W-1:0] region;
        logic [DATA_W-1:0] rdata;
    } mem_rsp_t;

    localparam int PAGE_BYTES = 1 << PAGE_OFFSET_BITS;
    localparam int VA_BITS    = VIRT_PAGE_BITS + PAGE_OFFSET_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_W-1:0]   opcode = '0;
    logic [PID_W-1:0]  process_id = '0;
    logic [SIZE_W-1:0] request_size = '0;
    logic [ADDR_W-1:0] address = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic done;
    logic status;
    logic [ADDR_W-1:0] region_address;
    logic [DATA_W-1:0] read_data;

    paged_frame_allocator_mmu u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .process_id(process_id), .request_size(request_size),
        .address(address), .write_data(write_data), .done(done), .status(status),
        .region_address(region_address), .read_data(read_data)
    );

    always #6 clk = ~clk;

    logic [PID_W-1:0]      owner_of [NUM_FRAMES];
    int                    seq_of   [NUM_FRAMES];
    int                    next_of  [NUM_FRAMES];
    bit                    last_of  [NUM_FRAMES];
    bit                    map_ok   [NUM_PROCS][VIRT_PAGES];
    int                    map_fr   [NUM_PROCS][VIRT_PAGES];
    int                    brk      [NUM_PROCS];
    logic [DATA_W-1:0]     mem_bytes [NUM_FRAMES*PAGE_BYTES];

    mem_req_t pending_reqs[$];
    mem_rsp_t expected_rsps[$];
    int errors = 0;
    int n_sent = 0;
    int sent_mark = 0;
    int n_checked = 0;
    int n_alloc_ok = 0;
    int n_free_ok = 0;
    int send_idle_pct = 0;

    function automatic bit translate(input int pid, input logic [ADDR_W-1:0] a, output int phys);
        int vpn;
        int fr;
        vpn = int'(a[VA_BITS-1:0]) >> PAGE_OFFSET_BITS;
        phys = 0;
        if (!map_ok[pid-1][vpn]) return 0;
        fr = map_fr[pid-1][vpn];
        if (owner_of[fr] != pid) return 0;
        phys = (fr << PAGE_OFFSET_BITS) | int'(a[PAGE_OFFSET_BITS-1:0]);
        return 1;
    endfunction

    function automatic mem_rsp_t predict_mem(input mem_req_t r);
        mem_rsp_t o;
        int pid;
        int n;
        int bp;
        int cnt;
        int picks[NUM_FRAMES];
        int phys;
        int fr;
        int vpn;
        o = '{st: 1'b1, region: '0, rdata: '0};
        pid = int'(r.pid);
        if (pid < 1 || pid > NUM_PROCS) return o;
        case (r.op)
            OP_ALLOC:
            begin
                n = (int'(r.size) + PAGE_BYTES - 1) >> PAGE_OFFSET_BITS;
                bp = brk[pid-1];
                cnt = 0;
                if (n > NUM_FRAMES || bp + n > VIRT_PAGES) return o;
                for (int i = 0; i < NUM_FRAMES && cnt < n; i++)
                begin
                    if (owner_of[i] == 0)
                    begin
                        picks[cnt] = i;
                        cnt++;
                    end
                end
                if (cnt < n) return o;
                o.st = 1'b0;
                o.region = ADDR_W'(bp << PAGE_OFFSET_BITS);
                for (int i = 0; i < n; i++)
                begin
                    fr = picks[i];
                    owner_of[fr] = PID_W'(pid);
                    seq_of[fr] = i;
                    last_of[fr] = (i + 1 == n);
                    next_of[fr] = (i + 1 == n) ? 0 : picks[i+1];
                    map_ok[pid-1][bp+i] = 1'b1;
                    map_fr[pid-1][bp+i] = fr;
                end
                brk[pid-1] = bp + n;
                if (n > 0) n_alloc_ok++;
            end
            OP_FREE:
            begin
                vpn = int'(r.addr[VA_BITS-1:0]) >> PAGE_OFFSET_BITS;
                if (!map_ok[pid-1][vpn]) return o;
                fr = map_fr[pid-1][vpn];
                if (seq_of[fr] != 0 || owner_of[fr] != pid) return o;
                for (int s = 0; s < NUM_FRAMES; s++)
                begin
                    owner_of[fr] = '0;
                    if (last_of[fr]) break;
                    fr = next_of[fr];
                end
                o.st = 1'b0;
                n_free_ok++;
            end
            OP_READ:
            begin
                if (translate(pid, r.addr, phys))
                begin
                    o.st = 1'b0;
                    o.rdata = mem_bytes[phys];
                end
            end
            default:
            begin
                if (translate(pid, r.addr, phys))
                begin
                    o.st = 1'b0;
                    mem_bytes[phys] = r.wdata;
                end
            end
        endcase
        return o;
    endfunction

    function automatic mem_req_t make_req(input logic [OP_W-1:0] op, input int pid,
                                          input int size, input int addr, input int wd);
        mem_req_t r;
        r.op = op;
        r.pid = PID_W'(pid);
        r.size = SIZE_W'(size);
        r.addr = ADDR_W'(addr);
        r.wdata = DATA_W'(wd);
        r.hold = 1'b0;
        return r;
    endfunction

    // drive at the falling edge; hold start until accepted
    always @(negedge clk)
    begin
        mem_req_t r;
        if (rst_n && start && (n_sent == sent_mark))
        begin
        end
        else if (rst_n)
        begin
            if (pending_reqs.size() != 0 && pending_reqs[0].hold && expected_rsps.size() != 0)
            begin
                start <= 1'b0;
            end
            else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                r = pending_reqs.pop_front();
                opcode <= r.op;
                process_id <= r.pid;
                request_size <= r.size;
                address <= r.addr;
                write_data <= r.wdata;
                start <= 1'b1;
                sent_mark = n_sent;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // accept request and check results at the rising edge
    always @(posedge clk)
    begin
        mem_rsp_t want;
        if (rst_n && start && !busy)
        begin
            expected_rsps.push_back(predict_mem('{op: opcode, pid: process_id,
                size: request_size, addr: address, wdata: write_data, hold: 1'b0}));
            n_sent++;
        end
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d region=%0h rdata=%0h",
                         $time, status, region_address, read_data);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                n_checked++;
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    errors++;
                end
                if (region_address !== want.region)
                begin
                    $display("%0t: region_address expected %0h actual %0h",
                             $time, want.region, region_address);
                    errors++;
                end
                if (read_data !== want.rdata)
                begin
                    $display("%0t: read_data expected %0h actual %0h",
                             $time, want.rdata, read_data);
                    errors++;
                end
            end
        end
    end

    function automatic mem_req_t random_req();
        int pick;
        int pid;
        pick = $urandom_range(99);
        pid = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(NUM_PROCS, 1);
        if (pick < 30)
            return make_req(OP_ALLOC, pid,
                ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(1200),
                $urandom_range(16383), $urandom_range(255));
        else if (pick < 45)
            return make_req(OP_FREE, pid, $urandom_range(32767),
                ($urandom_range(1) << 14 - 0) | ($urandom_range(12) << PAGE_OFFSET_BITS)
                | $urandom_range(255), $urandom_range(255));
        else if (pick < 70)
            return make_req(OP_READ, pid, $urandom_range(32767),
                ($urandom_range(3) == 0 ? $urandom_range(16383)
                 : ($urandom_range(12) << PAGE_OFFSET_BITS) | $urandom_range(255)),
                $urandom_range(255));
        else
            return make_req(OP_WRITE, pid, $urandom_range(32767),
                ($urandom_range(3) == 0 ? $urandom_range(16383)
                 : ($urandom_range(12) << PAGE_OFFSET_BITS) | $urandom_range(255)),
                $urandom_range(255));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || start)
            @(posedge clk);
    endtask

    initial
    begin
        mem_req_t r;
        int idle_phase[4] = '{0, 51, 0, 28};
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            owner_of[f] = '0;
            seq_of[f] = 0;
            next_of[f] = 0;
            last_of[f] = 1'b0;
        end
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            brk[p] = 1;
            for (int v = 0; v < VIRT_PAGES; v++)
            begin
                map_ok[p][v] = 1'b0;
                map_fr[p][v] = 0;
            end
        end
        foreach (mem_bytes[i]) mem_bytes[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // bad ids, zero size, max size, alloc/write/read/free chain, refused frees
        pending_reqs.push_back(make_req(OP_ALLOC, 0, 256, 0, 0));
        pending_reqs.push_back(make_req(OP_READ, 9, 0, 16383, 0));
        pending_reqs.push_back(make_req(OP_WRITE, 15, 0, 256, 255));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 32767, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 16384, 0, 0));
        pending_reqs.push_back(make_req(OP_READ, 1, 0, 256, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 600, 0, 0));
        pending_reqs.push_back(make_req(OP_WRITE, 1, 0, 16383 & 'h2ff | 'h200, 8'hA5));
        pending_reqs.push_back(make_req(OP_WRITE, 1, 0, 256, 8'hFF));
        pending_reqs.push_back(make_req(OP_READ, 1, 0, 256, 0));
        pending_reqs.push_back(make_req(OP_READ, 1, 0, 'h2ff, 0));
        pending_reqs.push_back(make_req(OP_FREE, 1, 0, 'h200, 0));
        pending_reqs.push_back(make_req(OP_FREE, 2, 0, 'h100, 0));
        pending_reqs.push_back(make_req(OP_FREE, 1, 0, 'h1ff, 0));
        pending_reqs.push_back(make_req(OP_FREE, 1, 0, 'h100, 0));
        pending_reqs.push_back(make_req(OP_READ, 1, 0, 'h100, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 2, 63 * 256, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 3, 16128, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 2, 1, 0, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 2, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FREE, 3, 0, 'h3f00, 0));
        pending_reqs.push_back(make_req(OP_READ, 1, 0, 'h100, 0));
        pending_reqs.push_back(make_req(OP_ALLOC, 3, 16128, 0, 0));
        pending_reqs.push_back(make_req(OP_FREE, 3, 0, 'h4100, 0));
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_phase[ph];
            for (int i = 0; i < 375; i++)
            begin
                r = random_req();
                if (ph == 2 && i == 200) r.hold = 1'b1;
                pending_reqs.push_back(r);
            end
            wait_drained();
        end
        repeat (300) @(posedge clk);
        $display("Checked %0d results of %0d requests; %0d allocations and %0d frees succeeded.",
                 n_checked, n_sent, n_alloc_ok, n_free_ok);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("tb_paged_frame_allocator_mmu: PASS");
        else
            $display("tb_paged_frame_allocator_mmu: FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb_paged_frame_allocator_mmu: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/pfa_pkg.sv
design/pfa_dp.sv
design/pfa_ctrl.sv
design/paged_frame_allocator_mmu.sv
design/pfa_checker.sv
tb/tb_paged_frame_allocator_mmu.sv
